[hw/rtl/qme_pkg.sv]
// qme_pkg: shared types and constants of the queue machine execute unit.
// No dependencies.
package qme_pkg;
  localparam int QDEPTH = 1024;
  localparam int QAW = 10;
  localparam int QCW = 11;
  localparam int NREGS = 26;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
    OP_MOD = 5'd5, OP_POPR = 5'd6, OP_PUSHR = 5'd7, OP_PRN = 5'd8, OP_PRNR = 5'd9,
    OP_CHR = 5'd10, OP_CHRR = 5'd11, OP_JMP = 5'd12, OP_JZ = 5'd13, OP_JEQ = 5'd14,
    OP_JGT = 5'd15, OP_QUIT = 5'd16, OP_NOP = 5'd17
  } op_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NUM = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;
  localparam logic [1:0] KIND_QUIT = 2'd3;
  localparam logic [1:0] FLT_OK = 2'd0;
  localparam logic [1:0] FLT_UNDER = 2'd1;
  localparam logic [1:0] FLT_OVER = 2'd2;

  typedef struct packed {
    logic [4:0]  op;
    logic [15:0] immediate;
    logic [4:0]  reg_a;
    logic [4:0]  reg_b;
    logic [15:0] target;
  } instr_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [15:0] out_value;
    logic        jump_taken;
    logic [15:0] jump_target;
    logic [1:0]  fault;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_POP1, ST_POP2, ST_DIV, ST_EXEC, ST_OUT
  } state_t;
endpackage

[hw/rtl/qme_if.sv]
// qme_instr_if, qme_result_if: valid/ready channels.
// Depends on qme_pkg.
interface qme_instr_if;
  logic valid;
  logic ready;
  qme_pkg::instr_t word;
  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

interface qme_result_if;
  logic valid;
  logic ready;
  qme_pkg::result_t word;
  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

[hw/rtl/qme_front.sv]
// qme_front: accepts instruction words into a two-entry queue.
// Depends on qme_pkg.
module qme_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  qme_pkg::instr_t in_word,
  output logic q_valid,
  input  logic q_ready,
  output qme_pkg::instr_t q_word
);
  qme_pkg::instr_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_word = mem_r[rp_r];
  assign wr = in_valid && in_ready;
  assign rd = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= in_word;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

[hw/rtl/qme_div.sv]
// qme_div: 16-bit restoring divider, one quotient bit per cycle.
// No dependencies beyond the language.
module qme_div (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic done,
  output logic [15:0] quo,
  output logic [15:0] rem
);
  logic [15:0] q_r, r_r, d_r;
  logic [4:0] cnt_r;
  logic busy_r;
  logic [16:0] trial;

  assign trial = {r_r, q_r[15]} - {1'b0, d_r};
  assign done = busy_r && (cnt_r == 5'd0);
  assign quo = q_r;
  assign rem = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 5'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 5'd16;
      q_r <= dividend;
      r_r <= 16'd0;
      d_r <= divisor;
    end else if (busy_r) begin
      if (cnt_r == 5'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 5'd1;
        if (!trial[16]) begin
          r_r <= trial[15:0];
          q_r <= {q_r[14:0], 1'b1};
        end else begin
          r_r <= {r_r[14:0], q_r[15]};
          q_r <= {q_r[14:0], 1'b0};
        end
      end
    end
  end
endmodule

[hw/rtl/qme_back.sv]
// qme_back: executes instructions against the data queue and register file.
// Depends on qme_pkg and qme_div.
module qme_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  qme_pkg::instr_t q_word,
  output logic out_valid,
  input  logic out_ready,
  output qme_pkg::result_t out_word
);
  logic [15:0] qmem [qme_pkg::QDEPTH];
  logic [15:0] rf_r [qme_pkg::NREGS];
  logic [qme_pkg::QAW-1:0] head_r, tail_r;
  logic [qme_pkg::QCW-1:0] count_r;
  qme_pkg::state_t st_r, st_nxt;
  qme_pkg::instr_t ins_r;
  qme_pkg::result_t res_r, res_nxt;
  logic [15:0] x_r, y_r, rd_data_r, ra_v, rb_v, wval;
  logic [31:0] prod;
  logic take, pop, push, rfw, dstart, ddone;
  logic [15:0] dq, dr;
  logic [qme_pkg::QAW-1:0] head_inc, tail_inc;

  assign head_inc = head_r + 1'b1;
  assign tail_inc = tail_r + 1'b1;
  assign ra_v = (ins_r.reg_a < 5'(qme_pkg::NREGS)) ? rf_r[ins_r.reg_a] : 16'd0;
  assign rb_v = (ins_r.reg_b < 5'(qme_pkg::NREGS)) ? rf_r[ins_r.reg_b] : 16'd0;
  assign prod = x_r * y_r;
  assign q_ready = (st_r == qme_pkg::ST_IDLE);
  assign take = q_valid && q_ready;
  assign out_valid = (st_r == qme_pkg::ST_OUT);
  assign out_word = res_r;

  qme_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(x_r), .divisor(y_r),
    .done(ddone), .quo(dq), .rem(dr)
  );

  always_comb begin
    st_nxt = st_r;
    res_nxt = res_r;
    pop = 1'b0;
    push = 1'b0;
    rfw = 1'b0;
    dstart = 1'b0;
    wval = 16'd0;
    unique case (st_r)
      qme_pkg::ST_IDLE: if (take) begin
        res_nxt = '0;
        case (q_word.op)
          qme_pkg::OP_ADD, qme_pkg::OP_SUB, qme_pkg::OP_MUL, qme_pkg::OP_DIV,
          qme_pkg::OP_MOD:
            if (count_r < 11'd2) begin
              res_nxt.fault = qme_pkg::FLT_UNDER;
              st_nxt = qme_pkg::ST_OUT;
            end else st_nxt = qme_pkg::ST_POP1;
          qme_pkg::OP_POPR, qme_pkg::OP_PRN, qme_pkg::OP_CHR:
            if (count_r == '0) begin
              res_nxt.fault = qme_pkg::FLT_UNDER;
              st_nxt = qme_pkg::ST_OUT;
            end else st_nxt = qme_pkg::ST_POP1;
          qme_pkg::OP_PUSH, qme_pkg::OP_PUSHR:
            if (count_r == 11'(qme_pkg::QDEPTH)) begin
              res_nxt.fault = qme_pkg::FLT_OVER;
              st_nxt = qme_pkg::ST_OUT;
            end else st_nxt = qme_pkg::ST_EXEC;
          default: st_nxt = qme_pkg::ST_EXEC;
        endcase
      end
      qme_pkg::ST_POP1: begin
        pop = 1'b1;
        if (ins_r.op inside {qme_pkg::OP_POPR, qme_pkg::OP_PRN, qme_pkg::OP_CHR})
          st_nxt = qme_pkg::ST_EXEC;
        else st_nxt = qme_pkg::ST_POP2;
      end
      qme_pkg::ST_POP2: begin
        pop = 1'b1;
        st_nxt = qme_pkg::ST_DIV;
      end
      qme_pkg::ST_DIV: begin
        if (ins_r.op == qme_pkg::OP_DIV || ins_r.op == qme_pkg::OP_MOD) begin
          if (y_r == 16'd0) st_nxt = qme_pkg::ST_EXEC;
          else begin
            dstart = 1'b1;
            st_nxt = qme_pkg::ST_EXEC;
          end
        end else st_nxt = qme_pkg::ST_EXEC;
      end
      qme_pkg::ST_EXEC: begin
        st_nxt = qme_pkg::ST_OUT;
        case (ins_r.op)
          qme_pkg::OP_PUSH: begin push = 1'b1; wval = ins_r.immediate; end
          qme_pkg::OP_PUSHR: begin push = 1'b1; wval = ra_v; end
          qme_pkg::OP_ADD: begin push = 1'b1; wval = x_r + y_r; end
          qme_pkg::OP_SUB: begin push = 1'b1; wval = x_r - y_r; end
          qme_pkg::OP_MUL: begin push = 1'b1; wval = prod[15:0]; end
          qme_pkg::OP_DIV, qme_pkg::OP_MOD: begin
            if (y_r == 16'd0) begin
              push = 1'b1;
            end else if (ddone) begin
              push = 1'b1;
              wval = (ins_r.op == qme_pkg::OP_DIV) ? dq : dr;
            end else st_nxt = qme_pkg::ST_EXEC;
          end
          qme_pkg::OP_POPR: begin rfw = 1'b1; wval = x_r; end
          qme_pkg::OP_PRN: begin
            res_nxt.out_kind = qme_pkg::KIND_NUM; res_nxt.out_value = x_r;
          end
          qme_pkg::OP_PRNR: begin
            res_nxt.out_kind = qme_pkg::KIND_NUM; res_nxt.out_value = ra_v;
          end
          qme_pkg::OP_CHR: begin
            res_nxt.out_kind = qme_pkg::KIND_CHAR; res_nxt.out_value = {8'd0, x_r[7:0]};
          end
          qme_pkg::OP_CHRR: begin
            res_nxt.out_kind = qme_pkg::KIND_CHAR; res_nxt.out_value = {8'd0, ra_v[7:0]};
          end
          qme_pkg::OP_JMP: begin
            res_nxt.jump_taken = 1'b1; res_nxt.jump_target = ins_r.target;
          end
          qme_pkg::OP_JZ: if (ra_v == 16'd0) begin
            res_nxt.jump_taken = 1'b1; res_nxt.jump_target = ins_r.target;
          end
          qme_pkg::OP_JEQ: if (ra_v == rb_v) begin
            res_nxt.jump_taken = 1'b1; res_nxt.jump_target = ins_r.target;
          end
          qme_pkg::OP_JGT: if (ra_v > rb_v) begin
            res_nxt.jump_taken = 1'b1; res_nxt.jump_target = ins_r.target;
          end
          qme_pkg::OP_QUIT: res_nxt.out_kind = qme_pkg::KIND_QUIT;
          default: ;
        endcase
      end
      qme_pkg::ST_OUT: if (out_ready) st_nxt = qme_pkg::ST_IDLE;
      default: st_nxt = qme_pkg::ST_IDLE;
    endcase
  end

  // read data is registered; a pop prefetches the entry after the one it takes
  always_ff @(posedge clk) begin
    rd_data_r <= qmem[pop ? head_inc : head_r];
    if (push) qmem[tail_r] <= wval;
  end

  always_ff @(posedge clk) begin
    if (take) ins_r <= q_word;
    res_r <= res_nxt;
    if (!rst_n) begin
      st_r <= qme_pkg::ST_IDLE;
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
      for (int i = 0; i < qme_pkg::NREGS; i++) rf_r[i] <= 16'd0;
    end else begin
      st_r <= st_nxt;
      if (pop) begin
        head_r <= head_inc;
        if (st_r == qme_pkg::ST_POP1) x_r <= rd_data_r;
        else y_r <= rd_data_r;
      end
      count_r <= count_r + {10'd0, push} - {10'd0, pop};
      if (push) tail_r <= tail_inc;
      if (rfw && ins_r.reg_a < 5'(qme_pkg::NREGS)) rf_r[ins_r.reg_a] <= wval;
    end
  end
endmodule

[hw/rtl/queue_machine_execute_unit.sv]
// Queue machine execute unit. One instruction word in on in_, one result word
// out on out_. A two-entry instruction queue decouples acceptance from execution.
// From input to result, pushes, jumps, prints from a register, quit and nop
// pass ST_EXEC and ST_OUT; a single pop adds ST_POP1; add, sub, mul, div and
// mod pass ST_POP1, ST_POP2 and ST_DIV, and a divide or remainder by a nonzero
// divisor waits in ST_EXEC for the 16-bit restoring divider. One instruction
// executes at a time; the back end takes a new word once out_ takes the result.
// Queue memory is 1024 x 16, read through a registered port, one pop a cycle.
// Reset (rst_n low, synchronous) empties the queue and clears the 26 registers.
// When the receiver stalls, the result holds on out_ and execution waits; the
// front still accepts up to two more words.
// Depends on qme_pkg, qme_if, qme_front, qme_div, qme_back.
module queue_machine_execute_unit (
  input logic clk,
  input logic rst_n,
  qme_instr_if.sink in_ch,
  qme_result_if.source out_ch
);
  logic q_valid, q_ready;
  qme_pkg::instr_t q_word;

  qme_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_word(in_ch.word), .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
  );

  qme_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_word(out_ch.word)
  );
endmodule
